// ===== src/aabb_collision_resolve_core_defines.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the box collision resolver
// Shared property templates: an implication in the same cycle or the next.
// -----------------------------------------------------------------------------
`ifndef AABB_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ACR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ACR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/acr_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acr_pkg
// Types, constants and helpers shared by the controller and the datapath.
// -----------------------------------------------------------------------------
package acr_pkg;

	localparam int WORD_BITS = 32;
	localparam int AXES      = 3;

	localparam int NAX   = (AXES < 1) ? 1 : ((AXES > 3) ? 3 : AXES);
	localparam int SAT_W = (WORD_BITS < 2) ? 2 : ((WORD_BITS > 32) ? 32 : WORD_BITS);

	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
	localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

	typedef struct packed {
		logic cap_first;
		logic cap_second;
		logic eval;
		logic sel;
		logic mul_a;
		logic mul_b;
		logic mul_c;
		logic sum;
		logic div_load_q;
		logic div_step;
		logic div_load_v;
		logic apply;
		logic which;
	} acr_cmd_t;

	typedef struct packed {
		logic go_div;
	} acr_status_t;

	// Clamp a wide signed value to the output word range.
	function automatic logic [31:0] acr_sat(input logic signed [33:0] x);
		logic signed [33:0] y;
		y = x;
		if (x > SAT_HI) y = SAT_HI;
		if (x < SAT_LO) y = SAT_LO;
		return y[31:0];
	endfunction

endpackage

// ===== src/acr_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acr_ctrl
// Sequencer: capture, overlap test, multiplies and two divisions (only on a collision with nonzero mass), two results.
// -----------------------------------------------------------------------------
module acr_ctrl import acr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	output logic        res_valid,
	input  logic        res_stall,
	input  acr_status_t status,
	output acr_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_EVAL, S_SEL, S_MUL_A, S_MUL_B, S_MUL_C, S_SUM,
		S_DIV_Q, S_LOAD_V, S_DIV_V, S_APPLY, S_OUT0, S_OUT1
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept;
	logic              cnt_end;

	assign accept     = item_valid && (state_q == S_IDLE);
	assign cnt_end    = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign item_stall = (state_q != S_IDLE);
	assign res_valid  = (state_q == S_OUT0) || (state_q == S_OUT1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && kind) state_q <= S_EVAL;
				end
				S_EVAL: state_q <= S_SEL;
				S_SEL: begin
					state_q <= status.go_div ? S_MUL_A : S_APPLY;
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MUL_C;
				S_MUL_C: state_q <= S_SUM;
				S_SUM: begin
					cnt_q   <= '0;
					state_q <= S_DIV_Q;
				end
				S_DIV_Q: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) state_q <= S_LOAD_V;
				end
				S_LOAD_V: begin
					cnt_q   <= '0;
					state_q <= S_DIV_V;
				end
				S_DIV_V: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) state_q <= S_APPLY;
				end
				S_APPLY: state_q <= S_OUT0;
				S_OUT0: begin
					if (!res_stall) state_q <= S_OUT1;
				end
				S_OUT1: begin
					if (!res_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.cap_first  = accept && !kind;
		cmd.cap_second = accept && kind;
		cmd.eval       = (state_q == S_EVAL);
		cmd.sel        = (state_q == S_SEL);
		cmd.mul_a      = (state_q == S_MUL_A);
		cmd.mul_b      = (state_q == S_MUL_B);
		cmd.mul_c      = (state_q == S_MUL_C);
		cmd.sum        = (state_q == S_SUM);
		cmd.div_load_q = (state_q == S_SUM);
		cmd.div_step   = (state_q == S_DIV_Q) || (state_q == S_DIV_V);
		cmd.div_load_v = (state_q == S_LOAD_V);
		cmd.apply      = (state_q == S_APPLY);
		cmd.which      = (state_q == S_OUT1);
	end

endmodule

// ===== src/acr_dp.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acr_dp
// Box registers, overlap test, multiplies, restoring divider, results.
// -----------------------------------------------------------------------------
module acr_dp import acr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  acr_cmd_t           cmd,
	output acr_status_t        status,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        size_x,
	input  logic [30:0]        size_y,
	input  logic [30:0]        size_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [30:0]        body_mass,
	output logic               collided,
	output logic               which_box,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic [1:0]         hit_axis,
	output logic               last
);

	logic signed [31:0] in_pos [3];
	logic [30:0]        in_size [3];
	logic signed [31:0] in_vel [3];

	logic signed [31:0] hp_q [3];
	logic [30:0]        hs_q [3];
	logic signed [31:0] hv_q [3];
	logic [30:0]        hm_q;
	logic signed [31:0] bp_q [3];
	logic [30:0]        bs_q [3];
	logic signed [31:0] bv_q [3];
	logic [30:0]        bm_q;

	logic [30:0]        ov_c [3];
	logic               below_c [3];
	logic               hit_c;
	logic [30:0]        ov_q [3];
	logic               below_q [3];
	logic               hit_q;

	logic [1:0]         axis_c;
	logic [1:0]         axis_q;
	logic [30:0]        ov_sel_q;
	logic               below_sel_q;
	logic [31:0]        tot_c;
	logic [31:0]        tot_q;

	logic [61:0]        prod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod2_q;

	logic [63:0]        dvd_q;
	logic [31:0]        rem_q;
	logic [32:0]        rem_nx;
	logic               ge;
	logic               neg_q;
	logic [30:0]        qa_q;

	logic signed [33:0] vc;
	logic [30:0]        qb;
	logic               upd;

	logic signed [33:0] rp1_q [3];
	logic signed [33:0] rv1_q [3];
	logic signed [33:0] rp2_q [3];
	logic signed [33:0] rv2_q [3];

	assign in_pos  = '{pos_x, pos_y, pos_z};
	assign in_size = '{size_x, size_y, size_z};
	assign in_vel  = '{vel_x, vel_y, vel_z};

	// Overlap per axis.
	always_comb begin
		logic signed [33:0] a0, a1, b0, b1, d;
		logic sep;
		hit_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			a0 = 34'(hp_q[i]);
			b0 = 34'(bp_q[i]);
			a1 = a0 + $signed({3'b000, hs_q[i]});
			b1 = b0 + $signed({3'b000, bs_q[i]});
			below_c[i] = (a0 < b0);
			if (below_c[i]) begin
				sep = (a1 <= b0);
				d   = a1 - b0;
			end else begin
				sep = (b1 <= a0);
				d   = b1 - a0;
			end
			ov_c[i] = d[30:0];
			if (i < NAX && sep) hit_c = 1'b0;
		end
	end

	// Least overlap, first axis wins ties.
	always_comb begin
		axis_c = 2'd0;
		for (int i = 1; i < NAX; i++) begin
			if (ov_q[i] < ov_q[axis_c]) axis_c = 2'(i);
		end
	end

	assign tot_c         = {1'b0, hm_q} + {1'b0, bm_q};
	assign status.go_div = hit_q && (tot_c != 32'd0);

	assign rem_nx = {rem_q, dvd_q[63]};
	assign ge     = (rem_nx >= {1'b0, tot_q});

	assign vc  = neg_q ? -$signed({1'b0, dvd_q[32:0]}) : $signed({1'b0, dvd_q[32:0]});
	assign qb  = ov_sel_q - qa_q;
	assign upd = hit_q && (tot_q != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				hp_q[i] <= '0;
				hs_q[i] <= '0;
				hv_q[i] <= '0;
			end
			hm_q <= '0;
		end else if (cmd.cap_first) begin
			hp_q <= in_pos;
			hs_q <= in_size;
			hv_q <= in_vel;
			hm_q <= body_mass;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_second) begin
			bp_q <= in_pos;
			bs_q <= in_size;
			bv_q <= in_vel;
			bm_q <= body_mass;
		end
		if (cmd.eval) begin
			ov_q    <= ov_c;
			below_q <= below_c;
			hit_q   <= hit_c;
		end
		if (cmd.sel) begin
			axis_q      <= axis_c;
			ov_sel_q    <= ov_q[axis_c];
			below_sel_q <= below_q[axis_c];
			tot_q       <= tot_c;
		end
		if (cmd.mul_a) prod_q <= ov_sel_q * bm_q;
		if (cmd.mul_b) acc_q <= $signed({1'b0, hm_q}) * hv_q[axis_q];
		if (cmd.mul_c) prod2_q <= $signed({1'b0, bm_q}) * bv_q[axis_q];
		if (cmd.sum) acc_q <= acc_q + prod2_q;
		if (cmd.div_load_q) begin
			dvd_q <= {2'b00, prod_q};
			rem_q <= '0;
		end else if (cmd.div_load_v) begin
			qa_q  <= dvd_q[30:0];
			neg_q <= acc_q[63];
			dvd_q <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 32'(rem_nx - {1'b0, tot_q}) : rem_nx[31:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
		if (cmd.apply) begin
			for (int i = 0; i < 3; i++) begin
				if (upd && axis_q == 2'(i)) begin
					rv1_q[i] <= vc;
					rv2_q[i] <= vc;
					if (below_sel_q) begin
						rp1_q[i] <= 34'(hp_q[i]) - $signed({3'b000, qa_q});
						rp2_q[i] <= 34'(bp_q[i]) + $signed({3'b000, qb});
					end else begin
						rp1_q[i] <= 34'(hp_q[i]) + $signed({3'b000, qa_q});
						rp2_q[i] <= 34'(bp_q[i]) - $signed({3'b000, qb});
					end
				end else begin
					rp1_q[i] <= 34'(hp_q[i]);
					rv1_q[i] <= 34'(hv_q[i]);
					rp2_q[i] <= 34'(bp_q[i]);
					rv2_q[i] <= 34'(bv_q[i]);
				end
			end
		end
	end

	assign collided  = hit_q;
	assign which_box = cmd.which;
	assign last      = cmd.which;
	assign hit_axis  = hit_q ? axis_q : AXIS_NONE;
	assign new_pos_x = acr_sat(cmd.which ? rp2_q[0] : rp1_q[0]);
	assign new_pos_y = acr_sat(cmd.which ? rp2_q[1] : rp1_q[1]);
	assign new_pos_z = acr_sat(cmd.which ? rp2_q[2] : rp1_q[2]);
	assign new_vel_x = acr_sat(cmd.which ? rv2_q[0] : rv1_q[0]);
	assign new_vel_y = acr_sat(cmd.which ? rv2_q[1] : rv1_q[1]);
	assign new_vel_z = acr_sat(cmd.which ? rv2_q[2] : rv1_q[2]);

endmodule

// ===== src/aabb_collision_resolve_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aabb_collision_resolve_core
// Resolves a collision between two axis-aligned boxes sent as two items.
// -----------------------------------------------------------------------------
// Usage:
//   Send the first box as an item with kind 0; it is held and gives no result.
//   Send the second box with kind 1; the block then tests overlap on each axis,
//   picks the axis of least overlap, splits the push by mass and sets both
//   velocities on that axis to the common inelastic value.
//   Two result items follow: the first box (which_box 0), then the second box
//   (which_box 1, last 1). Without a collision both carry their inputs.
// Sequence:
//   A kind 0 item is only captured; the sequencer stays idle and can take the
//   next item. A colliding kind 1 item runs the overlap test and axis choice,
//   the multiplies and their sum, two 64-step passes of the one-bit-per-cycle
//   restoring divider (push share, then common velocity) with a load of the
//   second dividend between, and the apply step, before its first result.
//   Without a collision or with zero total mass the multiplies and divider
//   are skipped. Items are not taken (item_stall high) until both results are
//   delivered.
// Reset: clears the sequencer and the held box to zero.
// Stall: while res_stall is high the current result item holds unchanged.
// -----------------------------------------------------------------------------
`include "aabb_collision_resolve_core_defines.svh"

module aabb_collision_resolve_core import acr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        size_x,
	input  logic [30:0]        size_y,
	input  logic [30:0]        size_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [30:0]        body_mass,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               collided,
	output logic               which_box,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic [1:0]         hit_axis,
	output logic               last
);

	acr_cmd_t    cmd;
	acr_status_t status;

	// Sequencer: owns both handshakes.
	acr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath: holds the boxes and does all arithmetic.
	acr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.size_x    (size_x),
		.size_y    (size_y),
		.size_z    (size_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.body_mass (body_mass),
		.collided  (collided),
		.which_box (which_box),
		.new_pos_x (new_pos_x),
		.new_pos_y (new_pos_y),
		.new_pos_z (new_pos_z),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y),
		.new_vel_z (new_vel_z),
		.hit_axis  (hit_axis),
		.last      (last)
	);

	// A taken first result is always followed by the second.
	`ACR_ASSERT_NXT(a_pair_follows, clk, arst_n, res_valid && !which_box && !res_stall, res_valid && last, "second result missing")
	// Results and new items never overlap.
	`ACR_ASSERT_IMP(a_no_accept_busy, clk, arst_n, res_valid, item_stall, "item taken while results pending")
	// The pair ends after the second result is taken.
	`ACR_ASSERT_NXT(a_pair_ends, clk, arst_n, res_valid && last && !res_stall, !res_valid, "extra result after pair")
	// Axis code agrees with the collision flag.
	`ACR_ASSERT_IMP(a_axis_flag, clk, arst_n, res_valid, collided == (hit_axis != AXIS_NONE), "hit_axis disagrees with collided")

endmodule
